FILE: rtl/ffd_pkg.sv
package ffd_pkg;

  // Default raw word width
  localparam int WordBitsDef = 64;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HIGH_BIT  = 2'd0;
  localparam logic [1:0] REG_BIT_COUNT = 2'd1;
  localparam logic [1:0] REG_SIGN_MODE = 2'd2;
  localparam logic [1:0] REG_SCALE     = 2'd3;

  // Fixed double patterns
  localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NAN_DEF  = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  // Field setup taken straight from the registers
  typedef struct packed {
    logic [5:0] high_bit;
    logic [6:0] bit_count;
    logic       sign_mode;
  } cfg_t;

  // Decoded weight, scale over 2^(n-1)
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic [63:0]        bits;
    logic [52:0]        mb;
    logic signed [12:0] eb;
  } wt_t;

  // Magnitude rounded to a double significand
  typedef struct packed {
    logic        invalid;
    logic        neg;
    logic        zero;
    logic [52:0] ma;
    logic [6:0]  ea;
  } mag_t;

endpackage

FILE: rtl/ffd_cfg.sv
module ffd_cfg
  import ffd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o,
  output wt_t         wt_o
);

  logic [5:0]  hb_q;
  logic [6:0]  bc_q;
  logic        sg_q;
  logic [63:0] sc_q;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= '0;
      bc_q <= 7'd1;
      sg_q <= 1'b0;
      sc_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_HIGH_BIT:  hb_q <= pwdata[5:0];
        REG_BIT_COUNT: bc_q <= pwdata[6:0];
        REG_SIGN_MODE: sg_q <= pwdata[0];
        REG_SCALE:     sc_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_HIGH_BIT:  prdata = 64'(hb_q);
      REG_BIT_COUNT: prdata = 64'(bc_q);
      REG_SIGN_MODE: prdata = 64'(sg_q);
      REG_SCALE:     prdata = sc_q;
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{high_bit: hb_q, bit_count: bc_q, sign_mode: sg_q};

  // Weight step 1: classify the scale and find the denormal shift
  logic        s_sign;
  logic [10:0] s_exp;
  logic [51:0] s_frac;
  logic [5:0]  k;
  logic [11:0] sh_wide;
  logic        w1_pass_d, w1_pass_q;
  logic [63:0] w1_bits_d, w1_bits_q;
  logic [52:0] w1_sig_d, w1_sig_q;
  logic [6:0]  w1_sh_d, w1_sh_q;
  logic        w1_sign_q;

  assign s_sign  = sc_q[63];
  assign s_exp   = sc_q[62:52];
  assign s_frac  = sc_q[51:0];
  assign k       = 6'(bc_q - 7'(sg_q) - 7'd1);
  assign sh_wide = 12'(k) - 12'(s_exp) + 12'd1;

  always_comb begin
    w1_pass_d = 1'b1;
    w1_bits_d = sc_q;
    w1_sig_d  = '0;
    w1_sh_d   = '0;
    if (s_exp == EXP_ALL_ONES) begin
      // Quiet a NaN, pass an infinity
      w1_bits_d = (s_frac != '0) ? (sc_q | (64'd1 << 51)) : sc_q;
    end else if (s_exp == '0 && s_frac == '0) begin
      w1_bits_d = DBL_ONE;
    end else if (s_exp != '0 && s_exp > 11'(k)) begin
      w1_bits_d = {s_sign, s_exp - 11'(k), s_frac};
    end else begin
      w1_pass_d = 1'b0;
      w1_sig_d  = {(s_exp != '0), s_frac};
      w1_sh_d   = (s_exp != '0) ? sh_wide[6:0] : 7'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    w1_pass_q <= w1_pass_d;
    w1_bits_q <= w1_bits_d;
    w1_sig_q  <= w1_sig_d;
    w1_sh_q   <= w1_sh_d;
    w1_sign_q <= s_sign;
  end

  // Weight step 2: shift into the denormal range and round to nearest even
  logic [52:0] lowmask;
  logic [53:0] ext;
  logic [52:0] q;
  logic        rnd, sticky, up;
  logic [63:0] w2_bits_d, w2_bits_q;

  assign lowmask = ~({53{1'b1}} << w1_sh_q);
  assign ext     = {w1_sig_q, 1'b0} >> w1_sh_q;
  assign q       = ext[53:1];
  assign rnd     = ext[0];
  assign sticky  = |(w1_sig_q & (lowmask >> 1));
  assign up      = rnd & (sticky | q[0]);

  always_comb begin
    if (w1_pass_q) begin
      w2_bits_d = w1_bits_q;
    end else begin
      w2_bits_d = {w1_sign_q, 63'(q) + 63'(up)};
    end
  end

  always_ff @(posedge clk_i) begin
    w2_bits_q <= w2_bits_d;
  end

  // Weight step 3: unpack and normalize the significand
  logic [10:0] w_exp;
  logic [51:0] w_frac;
  logic [5:0]  lead;
  wt_t         wt_d, wt_q;

  assign w_exp  = w2_bits_q[62:52];
  assign w_frac = w2_bits_q[51:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 52; i++) begin
      if (w_frac[i]) lead = 6'(i);
    end
    wt_d.sign = w2_bits_q[63];
    wt_d.nan  = (w_exp == EXP_ALL_ONES) && (w_frac != '0);
    wt_d.inf  = (w_exp == EXP_ALL_ONES) && (w_frac == '0);
    wt_d.zero = (w_exp == '0) && (w_frac == '0);
    wt_d.bits = w2_bits_q;
    if (w_exp != '0) begin
      wt_d.mb = {1'b1, w_frac};
      wt_d.eb = $signed({2'b0, w_exp}) - 13'sd1023;
    end else begin
      wt_d.mb = 53'(w_frac) << (6'd52 - lead);
      wt_d.eb = $signed({7'b0, lead}) - 13'sd1074;
    end
  end

  always_ff @(posedge clk_i) begin
    wt_q <= wt_d;
  end

  assign wt_o = wt_q;

endmodule

FILE: rtl/ffd_int2dbl.sv
module ffd_int2dbl
  import ffd_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef
)
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] raw_i,
  input  cfg_t                 cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mag_t                 mag_o
);

  logic [3:0] v_q;
  logic [3:0] en;

  // Advance a stage when it is empty or the next one moves
  assign en[3] = !v_q[3] || out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  // Stage 0: hold the raw word
  logic [63:0] raw0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) raw0_q <= 64'(raw_i);
  end

  // Stage 1: check the setup, extract the field, split off the sign
  logic [6:0]  min_w, hb_ext, shift_w, n;
  logic [63:0] field, mask;
  logic        bad;
  logic [63:0] s1_mag_q;
  logic        s1_neg_q, s1_inv_q;

  assign min_w   = cfg_i.sign_mode ? 7'd2 : 7'd1;
  assign hb_ext  = {1'b0, cfg_i.high_bit};
  assign bad     = (cfg_i.bit_count < min_w) || (cfg_i.bit_count > 7'(WORD_BITS)) ||
                   (hb_ext >= 7'(WORD_BITS)) || (hb_ext + 7'd1 < cfg_i.bit_count);
  assign shift_w = hb_ext + 7'd1 - cfg_i.bit_count;
  assign field   = raw0_q >> shift_w[5:0];
  assign n       = cfg_i.bit_count - 7'(cfg_i.sign_mode);
  assign mask    = ~({64{1'b1}} << n);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_mag_q <= field & mask;
      s1_neg_q <= cfg_i.sign_mode & field[cfg_i.bit_count[5:0] - 6'd1];
      s1_inv_q <= bad;
    end
  end

  // Stage 2: locate the leading one
  logic [5:0]  lead;
  logic [63:0] s2_mag_q;
  logic [5:0]  s2_lead_q;
  logic        s2_zero_q, s2_neg_q, s2_inv_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (s1_mag_q[i]) lead = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_mag_q  <= s1_mag_q;
      s2_lead_q <= lead;
      s2_zero_q <= (s1_mag_q == '0);
      s2_neg_q  <= s1_neg_q;
      s2_inv_q  <= s1_inv_q;
    end
  end

  // Stage 3: normalize and round to 53 bits, nearest even
  logic [63:0] norm;
  logic [53:0] sum;
  logic        up;
  mag_t        s3_q;

  assign norm = s2_mag_q << (6'd63 - s2_lead_q);
  assign up   = norm[10] & ((|norm[9:0]) | norm[11]);
  assign sum  = {1'b0, norm[63:11]} + 54'(up);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_q.invalid <= s2_inv_q;
      s3_q.neg     <= s2_neg_q;
      s3_q.zero    <= s2_zero_q;
      s3_q.ma      <= sum[53] ? {1'b1, 52'b0} : sum[52:0];
      s3_q.ea      <= 7'(s2_lead_q) + 7'(sum[53]);
    end
  end

  assign mag_o = s3_q;

endmodule

FILE: rtl/ffd_mul.sv
module ffd_mul
  import ffd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mag_t        mag_i,
  input  wt_t         wt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o,
  output logic        invalid_o
);

  logic [3:0] v_q;
  logic [3:0] en;

  assign en[3] = !v_q[3] || out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  // Carry the item flags along the stages
  logic [2:0] f4_q, f5_q, f6_q;

  // Stage 4: partial products, exponent sum
  logic [53:0]        pll_q;
  logic [52:0]        plh_q, phl_q;
  logic [51:0]        phh_q;
  logic signed [12:0] e4_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pll_q <= mag_i.ma[26:0]  * wt_i.mb[26:0];
      plh_q <= mag_i.ma[26:0]  * wt_i.mb[52:27];
      phl_q <= mag_i.ma[52:27] * wt_i.mb[26:0];
      phh_q <= mag_i.ma[52:27] * wt_i.mb[52:27];
      e4_q  <= $signed({6'b0, mag_i.ea}) + wt_i.eb;
      f4_q  <= {mag_i.invalid, mag_i.neg, mag_i.zero};
    end
  end

  // Stage 5: add the partial products
  logic [105:0]       p5_q;
  logic signed [12:0] e5_q;
  logic [53:0]        mid;

  assign mid = 54'(plh_q) + 54'(phl_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p5_q <= (106'(phh_q) << 54) + (106'(mid) << 27) + 106'(pll_q);
      e5_q <= e4_q;
      f5_q <= f4_q;
    end
  end

  // Stage 6: normalize by one bit, pick the exponent and right shift
  logic               top;
  logic signed [12:0] be;
  logic [105:0]       n6_q;
  logic [10:0]        base6_q;
  logic [6:0]         sh6_q;
  logic               ovf6_q;

  assign top = p5_q[105];
  assign be  = e5_q + $signed({12'b0, top}) + 13'sd1023;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n6_q   <= top ? p5_q : (p5_q << 1);
      ovf6_q <= (be >= 13'sd2047);
      if (be >= 13'sd1) begin
        base6_q <= be[10:0] - 11'd1;
        sh6_q   <= 7'd53;
      end else begin
        base6_q <= '0;
        sh6_q   <= 7'(13'sd54 - be);
      end
      f6_q <= f5_q;
    end
  end

  // Stage 7: round, pack, handle specials, apply the sign
  logic [105:0] lowmask, below, shifted;
  logic [52:0]  q;
  logic         rnd, sticky, up;
  logic [62:0]  packed_mag;
  logic [63:0]  res;
  logic [63:0]  result_q;
  logic         invalid_q;

  assign lowmask    = ~({106{1'b1}} << sh6_q);
  assign below      = n6_q & lowmask;
  assign shifted    = n6_q >> sh6_q;
  assign q          = shifted[52:0];
  assign rnd        = below[sh6_q - 7'd1];
  assign sticky     = |(below & (lowmask >> 1));
  assign up         = rnd & (sticky | q[0]);
  assign packed_mag = {base6_q, 52'b0} + 63'(q) + 63'(up);

  always_comb begin
    if (wt_i.nan) begin
      res = wt_i.bits;
    end else if (wt_i.inf) begin
      res = f6_q[0] ? DBL_NAN_DEF : {wt_i.sign, EXP_ALL_ONES, 52'b0};
    end else if (wt_i.zero || f6_q[0]) begin
      res = {wt_i.sign, 63'b0};
    end else if (ovf6_q) begin
      res = {wt_i.sign, EXP_ALL_ONES, 52'b0};
    end else begin
      res = {wt_i.sign, packed_mag};
    end
    res[63] = res[63] ^ f6_q[1];
    if (f6_q[2]) res = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      result_q  <= res;
      invalid_q <= f6_q[2];
    end
  end

  assign result_o  = result_q;
  assign invalid_o = invalid_q;

endmodule

FILE: rtl/fixed_field_to_double.sv
// Fixed point field to IEEE 754 double converter.
// Input channel: raw_word_i with in_valid_i / in_ready_o. Output channel:
// result_bits_o and invalid_setup_o with out_valid_o / out_ready_i. A
// transaction moves when valid and ready are both high at a clock edge.
// The field setup and scale are written over the APB port (8-byte spaced
// registers: high bit, bit count, signed flag, scale pattern); the user is
// to write them only while no transaction is in flight, which the block
// itself does not enforce. The weight derived from them passes the weight
// step registers and is ready ahead of the multiplier stage that uses it.
// Throughput: one transaction per cycle unless out_ready_i stalls the
// output, through the eight register stages in order (input hold, field
// extract, leading one, round, partial products, sum, normalize, round and
// pack). When the receiver holds out_ready_i low the result stays put, and
// empty stages still fill, so up to eight transactions are taken before
// in_ready_o drops. Reset clears all valid bits and loads the registers
// with high bit 0, bit count 1, unsigned, scale 0 (a weight of 1.0).
module fixed_field_to_double
  import ffd_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef
)
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] raw_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          result_bits_o,
  output logic                 invalid_setup_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  cfg_t cfg;
  wt_t  wt;
  mag_t mag;
  logic mag_valid, mag_ready;

  ffd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wt_o    (wt)
  );

  ffd_int2dbl #(
    .WORD_BITS (WORD_BITS)
  ) u_int2dbl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_i       (raw_word_i),
    .cfg_i       (cfg),
    .out_valid_o (mag_valid),
    .out_ready_i (mag_ready),
    .mag_o       (mag)
  );

  ffd_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mag_valid),
    .in_ready_o  (mag_ready),
    .mag_i       (mag),
    .wt_i        (wt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_bits_o),
    .invalid_o   (invalid_setup_o)
  );

endmodule

FILE: rtl/ffd_chk.sv
module ffd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_bits_o,
  input logic        invalid_setup_o,
  input logic        pready
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bits_o))
    else $error("stalled result changed");

  // Drive +0.0 on a bad setup
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_setup_o |-> result_bits_o == 64'd0)
    else $error("bad setup result not zero");

  // Take input whenever the output register is free
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with free output");

  // Never stall the configuration port
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind fixed_field_to_double ffd_chk u_chk (.*);
